// ----- sv/mpeg_audio_header_decode_defines.svh -----
// Shared assertion macros for the header decoder.
`ifndef MPEG_AUDIO_HEADER_DECODE_DEFINES_SVH
`define MPEG_AUDIO_HEADER_DECODE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MAHD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define MAHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mahd_pkg.sv -----
package mahd_pkg;

  localparam logic [10:0] SYNC_PATTERN = 11'h7FF;
  localparam logic [1:0]  LAYER_III    = 2'b01;

  // Version field of the header
  localparam logic [1:0] VBITS_MPEG25 = 2'b00;
  localparam logic [1:0] VBITS_RSVD   = 2'b01;
  localparam logic [1:0] VBITS_MPEG2  = 2'b10;
  localparam logic [1:0] VBITS_MPEG1  = 2'b11;

  // Version codes on the result
  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG1  = 2'd2;

  localparam logic [3:0] BR_FREE   = 4'd0;
  localparam logic [3:0] BR_RSVD   = 4'd15;
  localparam logic [1:0] SR_RSVD   = 2'd3;
  localparam logic [1:0] MODE_MONO = 2'd3;

  localparam logic [9:0]  KBPS_SCALE = 10'd1000;
  // floor(x/49) as (x*RECIP_49) >> RECIP_SHIFT, exact for x below 2^16
  localparam logic [16:0] RECIP_49    = 17'd85599;
  localparam int          RECIP_SHIFT = 22;

  localparam logic [16:0] MIN_FRAME_BYTES = 17'd4;
  localparam logic [16:0] MAX_FRAME_BYTES = 17'd1441;

  localparam logic [10:0] SPF_MPEG1 = 11'd1152;
  localparam logic [10:0] SPF_LSF   = 11'd576;
  localparam logic [5:0]  SIDE_M1_MONO   = 6'd17;
  localparam logic [5:0]  SIDE_M1_STEREO = 6'd32;
  localparam logic [5:0]  SIDE_LSF_MONO  = 6'd9;
  localparam logic [5:0]  SIDE_LSF_STEREO = 6'd17;
  localparam logic [1:0]  CH_MONO   = 2'd1;
  localparam logic [1:0]  CH_STEREO = 2'd2;

  // Decoded header after the first stage
  typedef struct packed {
    logic        ok;
    logic [1:0]  ver;
    logic [15:0] rate;
    logic [8:0]  kbps;
    logic [8:0]  mult;
    logic        div49;
    logic        half;
    logic        pad;
    logic        mono;
  } hdr_t;

  // After the scaling multiplies
  typedef struct packed {
    logic        ok;
    logic [1:0]  ver;
    logic [15:0] rate;
    logic [18:0] bitrate;
    logic [15:0] prod;
    logic        div49;
    logic        half;
    logic        pad;
    logic        mono;
  } prod_t;

  // After the reciprocal multiply
  typedef struct packed {
    logic        ok;
    logic [1:0]  ver;
    logic [15:0] rate;
    logic [18:0] bitrate;
    logic [10:0] quot49;
    logic [15:0] base_alt;
    logic        div49;
    logic        pad;
    logic        mono;
  } quot_t;

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  version_code;
    logic [15:0] sample_rate_hz;
    logic [18:0] bitrate_bps;
    logic [10:0] samples_per_frame;
    logic [1:0]  channel_count;
    logic [10:0] frame_length;
    logic [5:0]  side_info_bytes;
  } res_t;

  typedef struct packed {
    logic [8:0] mult;
    logic       div49;
    logic       half;
  } scale_t;

  function automatic logic [8:0] kbps_lookup(input logic mpeg1, input logic [3:0] ix);
    logic [8:0] k;
    k = '0;
    if (mpeg1) begin
      unique case (ix)
        4'd1:    k = 9'd32;
        4'd2:    k = 9'd40;
        4'd3:    k = 9'd48;
        4'd4:    k = 9'd56;
        4'd5:    k = 9'd64;
        4'd6:    k = 9'd80;
        4'd7:    k = 9'd96;
        4'd8:    k = 9'd112;
        4'd9:    k = 9'd128;
        4'd10:   k = 9'd160;
        4'd11:   k = 9'd192;
        4'd12:   k = 9'd224;
        4'd13:   k = 9'd256;
        4'd14:   k = 9'd320;
        default: k = 9'd0;
      endcase
    end else begin
      unique case (ix)
        4'd1:    k = 9'd8;
        4'd2:    k = 9'd16;
        4'd3:    k = 9'd24;
        4'd4:    k = 9'd32;
        4'd5:    k = 9'd40;
        4'd6:    k = 9'd48;
        4'd7:    k = 9'd56;
        4'd8:    k = 9'd64;
        4'd9:    k = 9'd80;
        4'd10:   k = 9'd96;
        4'd11:   k = 9'd112;
        4'd12:   k = 9'd128;
        4'd13:   k = 9'd144;
        4'd14:   k = 9'd160;
        default: k = 9'd0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sr);
    logic [15:0] r;
    r = '0;
    unique case ({ver, sr})
      {VER_MPEG25, 2'd0}: r = 16'd11025;
      {VER_MPEG25, 2'd1}: r = 16'd12000;
      {VER_MPEG25, 2'd2}: r = 16'd8000;
      {VER_MPEG2,  2'd0}: r = 16'd22050;
      {VER_MPEG2,  2'd1}: r = 16'd24000;
      {VER_MPEG2,  2'd2}: r = 16'd16000;
      {VER_MPEG1,  2'd0}: r = 16'd44100;
      {VER_MPEG1,  2'd1}: r = 16'd48000;
      {VER_MPEG1,  2'd2}: r = 16'd32000;
      default:            r = 16'd0;
    endcase
    return r;
  endfunction

  // coeff*1000/rate reduced per rate: kbps*mult, then /49, /2 or as is
  function automatic scale_t scale_lookup(input logic [1:0] ver, input logic [1:0] sr);
    scale_t s;
    s = '0;
    unique case ({ver, sr})
      {VER_MPEG25, 2'd0}: s = '{mult: 9'd320, div49: 1'b1, half: 1'b0};
      {VER_MPEG25, 2'd1}: s = '{mult: 9'd6,   div49: 1'b0, half: 1'b0};
      {VER_MPEG25, 2'd2}: s = '{mult: 9'd9,   div49: 1'b0, half: 1'b0};
      {VER_MPEG2,  2'd0}: s = '{mult: 9'd160, div49: 1'b1, half: 1'b0};
      {VER_MPEG2,  2'd1}: s = '{mult: 9'd3,   div49: 1'b0, half: 1'b0};
      {VER_MPEG2,  2'd2}: s = '{mult: 9'd9,   div49: 1'b0, half: 1'b1};
      {VER_MPEG1,  2'd0}: s = '{mult: 9'd160, div49: 1'b1, half: 1'b0};
      {VER_MPEG1,  2'd1}: s = '{mult: 9'd3,   div49: 1'b0, half: 1'b0};
      {VER_MPEG1,  2'd2}: s = '{mult: 9'd9,   div49: 1'b0, half: 1'b1};
      default:            s = '0;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/mahd_field_decode.sv -----
`include "mpeg_audio_header_decode_defines.svh"

module mahd_field_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        header_word,
  output logic               out_valid,
  input  logic               out_ready,
  output mahd_pkg::hdr_t     out_data
);

  logic           valid;
  mahd_pkg::hdr_t hdr;
  mahd_pkg::hdr_t hdr_next;
  mahd_pkg::scale_t scl;
  logic [1:0]     vbits;
  logic [1:0]     sr_ix;
  logic [3:0]     br_ix;
  logic [1:0]     ver;
  logic           ver_ok;

  assign vbits = header_word[20:19];
  assign br_ix = header_word[15:12];
  assign sr_ix = header_word[11:10];

  always_comb begin
    ver    = mahd_pkg::VER_MPEG25;
    ver_ok = 1'b1;
    unique case (vbits)
      mahd_pkg::VBITS_MPEG25: ver = mahd_pkg::VER_MPEG25;
      mahd_pkg::VBITS_MPEG2:  ver = mahd_pkg::VER_MPEG2;
      mahd_pkg::VBITS_MPEG1:  ver = mahd_pkg::VER_MPEG1;
      default:                ver_ok = 1'b0;
    endcase
  end

  always_comb begin
    scl = mahd_pkg::scale_lookup(ver, sr_ix);
    hdr_next.ok    = (header_word[31:21] == mahd_pkg::SYNC_PATTERN) && ver_ok &&
                     (header_word[18:17] == mahd_pkg::LAYER_III) &&
                     (br_ix != mahd_pkg::BR_FREE) && (br_ix != mahd_pkg::BR_RSVD) &&
                     (sr_ix != mahd_pkg::SR_RSVD);
    hdr_next.ver   = ver;
    hdr_next.rate  = mahd_pkg::rate_lookup(ver, sr_ix);
    hdr_next.kbps  = mahd_pkg::kbps_lookup(ver == mahd_pkg::VER_MPEG1, br_ix);
    hdr_next.mult  = scl.mult;
    hdr_next.div49 = scl.div49;
    hdr_next.half  = scl.half;
    hdr_next.pad   = header_word[9];
    hdr_next.mono  = (header_word[7:6] == mahd_pkg::MODE_MONO);
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hdr <= hdr_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = hdr;

  `MAHD_ASSERT_NEXT(a_bad_sync_rejected,
    in_valid && in_ready && (header_word[31:21] != mahd_pkg::SYNC_PATTERN),
    !out_data.ok, "header with bad sync marked ok")

endmodule

// ----- sv/mahd_len_calc.sv -----
`include "mpeg_audio_header_decode_defines.svh"

module mahd_len_calc (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mahd_pkg::hdr_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mahd_pkg::quot_t    out_data
);

  // Stage 2: scale kbps; stage 3: reciprocal multiply for the /49 rates
  logic            valid2;
  logic            valid3;
  logic            ready2;
  logic            ready3;
  mahd_pkg::prod_t p2;
  mahd_pkg::prod_t p2_next;
  mahd_pkg::quot_t q3;
  mahd_pkg::quot_t q3_next;
  logic [17:0]     prod_full;
  logic [32:0]     recip_full;

  assign prod_full = 18'(in_data.kbps) * 18'(in_data.mult);

  always_comb begin
    p2_next.ok      = in_data.ok;
    p2_next.ver     = in_data.ver;
    p2_next.rate    = in_data.rate;
    p2_next.bitrate = 19'(in_data.kbps) * 19'(mahd_pkg::KBPS_SCALE);
    p2_next.prod    = prod_full[15:0];
    p2_next.div49   = in_data.div49;
    p2_next.half    = in_data.half;
    p2_next.pad     = in_data.pad;
    p2_next.mono    = in_data.mono;
  end

  assign recip_full = 33'(p2.prod) * 33'(mahd_pkg::RECIP_49);

  always_comb begin
    q3_next.ok       = p2.ok;
    q3_next.ver      = p2.ver;
    q3_next.rate     = p2.rate;
    q3_next.bitrate  = p2.bitrate;
    q3_next.quot49   = recip_full[mahd_pkg::RECIP_SHIFT +: 11];
    q3_next.base_alt = p2.half ? (p2.prod >> 1) : p2.prod;
    q3_next.div49    = p2.div49;
    q3_next.pad      = p2.pad;
    q3_next.mono     = p2.mono;
  end

  assign ready3   = !valid3 || out_ready;
  assign ready2   = !valid2 || ready3;
  assign in_ready = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (ready2) begin
        valid2 <= in_valid;
      end
      if (ready3) begin
        valid3 <= valid2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && in_valid) begin
      p2 <= p2_next;
    end
    if (ready3 && valid2) begin
      q3 <= q3_next;
    end
  end

  assign out_valid = valid3;
  assign out_data  = q3;

  `MAHD_ASSERT_NEXT(a_stage3_holds, valid3 && !out_ready,
    valid3 && $stable(q3), "stage 3 dropped or changed a stalled transaction")

endmodule

// ----- sv/mahd_result.sv -----
`include "mpeg_audio_header_decode_defines.svh"

module mahd_result (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mahd_pkg::quot_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mahd_pkg::res_t     out_data
);

  logic            valid;
  mahd_pkg::res_t  res;
  mahd_pkg::res_t  res_next;
  logic [15:0]     base;
  logic [16:0]     flen;
  logic            good;
  logic            mpeg1;

  always_comb begin
    base  = in_data.div49 ? 16'(in_data.quot49) : in_data.base_alt;
    flen  = 17'(base) + 17'(in_data.pad);
    mpeg1 = (in_data.ver == mahd_pkg::VER_MPEG1);
    good  = in_data.ok && (flen >= mahd_pkg::MIN_FRAME_BYTES) &&
            (flen <= mahd_pkg::MAX_FRAME_BYTES);
    res_next = '0;
    if (good) begin
      res_next.valid_res         = 1'b1;
      res_next.version_code      = in_data.ver;
      res_next.sample_rate_hz    = in_data.rate;
      res_next.bitrate_bps       = in_data.bitrate;
      res_next.samples_per_frame = mpeg1 ? mahd_pkg::SPF_MPEG1 : mahd_pkg::SPF_LSF;
      res_next.channel_count     = in_data.mono ? mahd_pkg::CH_MONO : mahd_pkg::CH_STEREO;
      res_next.frame_length      = flen[10:0];
      if (mpeg1) begin
        res_next.side_info_bytes = in_data.mono ? mahd_pkg::SIDE_M1_MONO
                                                : mahd_pkg::SIDE_M1_STEREO;
      end else begin
        res_next.side_info_bytes = in_data.mono ? mahd_pkg::SIDE_LSF_MONO
                                                : mahd_pkg::SIDE_LSF_STEREO;
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = res;

  `MAHD_ASSERT_SAME(a_len_in_range, valid && res.valid_res,
    (res.frame_length >= 11'(mahd_pkg::MIN_FRAME_BYTES)) &&
    (res.frame_length <= 11'(mahd_pkg::MAX_FRAME_BYTES)),
    "accepted header with frame length out of range")
  `MAHD_ASSERT_SAME(a_reject_zeroed, valid && !res.valid_res, res == '0,
    "rejected header with non-zero fields")

endmodule

// ----- sv/mpeg_audio_header_decode.sv -----
// Channel  Dir  tdata                                     tuser
// s_axis   in   [31:0] header_word                        -
// m_axis   out  version_code, sample_rate_hz, bitrate_bps, [0] valid_res
//               samples_per_frame, channel_count,
//               frame_length, side_info_bytes (72 bits)
//
// One header per cycle unless m_axis_tready stalls the pipeline.
// Four register stages: field decode and table lookup, kbps scaling, the
// reciprocal multiply that divides by 49, and range check with result register.
// Synchronous reset clears the stage valid bits only; no clearing pass.
// Each stage stalls only when it is full and the next one cannot take its item.
module mpeg_audio_header_decode (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] header_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [1:0] version_code, [17:2] sample_rate_hz,
                                      // [36:18] bitrate_bps, [47:37] samples_per_frame,
                                      // [49:48] channel_count, [60:50] frame_length,
                                      // [66:61] side_info_bytes, [71:67] zero
  output logic        m_axis_tuser    // [0] valid_res
);

  logic            dec_valid;
  logic            dec_ready;
  mahd_pkg::hdr_t  dec_data;
  logic            len_valid;
  logic            len_ready;
  mahd_pkg::quot_t len_data;
  mahd_pkg::res_t  res;

  mahd_field_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .header_word (s_axis_tdata),
    .out_valid   (dec_valid),
    .out_ready   (dec_ready),
    .out_data    (dec_data)
  );

  mahd_len_calc u_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (len_valid),
    .out_ready (len_ready),
    .out_data  (len_data)
  );

  mahd_result u_result (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (len_valid),
    .in_ready  (len_ready),
    .in_data   (len_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {5'b0, res.side_info_bytes, res.frame_length, res.channel_count,
                         res.samples_per_frame, res.bitrate_bps, res.sample_rate_hz,
                         res.version_code};
  assign m_axis_tuser = res.valid_res;

endmodule
